/* src/tcgr_pkg.sv */
// ----------------------------------------------------------------------------
// Text console glyph renderer package
// Shared constants, codes and the command and status types that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package tcgr_pkg;

	localparam int GLYPH_WIDTH = 8;
	localparam int GLYPH_WIDTH_SH = 3;

	localparam int DEF_GLYPH_COUNT = 256;
	localparam int DEF_GLYPH_HEIGHT = 16;
	localparam int DEF_MAX_LINE_PIXELS = 4096;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_W = 32;
	localparam int GEOM_W = 13;
	localparam int COLOR_W = 32;
	localparam int OFFSET_W = 24;
	localparam int OP_W = 2;
	localparam int CHAR_W = 8;
	localparam int GROW_W = 4;
	localparam int BITS_W = 8;

	localparam int LINE_W = 8;
	localparam int MAX_LINES = 256;
	localparam int LINES_W = 9;
	localparam int RECIP_SHIFT = 18;

	localparam logic [GEOM_W-1:0] RST_LINE_PIXELS = 13'd640;
	localparam logic [GEOM_W-1:0] RST_SCREEN_HEIGHT = 13'd480;
	localparam logic [COLOR_W-1:0] RST_FG_COLOR = 32'h00FF_FFFF;
	localparam logic [COLOR_W-1:0] RST_BG_COLOR = 32'h0000_0000;

	localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CHAR_RETURN = 8'd13;

	typedef enum logic [OP_W-1:0] {
		OP_PRINT = 2'd0,
		OP_ERASE = 2'd1,
		OP_LOAD  = 2'd2
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_PIXELS   = 2'd0,
		REG_SCREEN_HEIGHT = 2'd1,
		REG_FG_COLOR      = 2'd2,
		REG_BG_COLOR      = 2'd3
	} reg_index_t;

	typedef enum logic [2:0] {
		KIND_NONE    = 3'd0,
		KIND_LOAD    = 3'd1,
		KIND_PRINT   = 3'd2,
		KIND_ERASE   = 3'd3,
		KIND_NEWLINE = 3'd4,
		KIND_RETURN  = 3'd5
	} kind_t;

	typedef struct packed {
		logic capture;
		logic decode;
		logic geom;
		logic move;
		logic yrow;
		logic base;
		logic issue;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  issue_ok;
		logic  row_last;
	} status_t;

endpackage

/* src/tcgr_ifs.sv */
// ----------------------------------------------------------------------------
// Text console glyph renderer channel interfaces
// Valid/ready channels for the command items and the row write beats.
// ----------------------------------------------------------------------------
interface tcgr_in_if;
	import tcgr_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [CHAR_W-1:0] character;
	logic [GROW_W-1:0] glyph_row;
	logic [BITS_W-1:0] glyph_bits;

	modport source (output valid, opcode, character, glyph_row, glyph_bits, input ready);
	modport sink (input valid, opcode, character, glyph_row, glyph_bits, output ready);
endinterface

interface tcgr_out_if;
	import tcgr_pkg::*;

	logic                valid;
	logic                ready;
	logic [OFFSET_W-1:0] pixel_offset;
	logic [BITS_W-1:0]   row_pattern;
	logic [COLOR_W-1:0]  fore_color;
	logic [COLOR_W-1:0]  back_color;
	logic                last_row;

	modport source (output valid, pixel_offset, row_pattern, fore_color, back_color, last_row,
		input ready);
	modport sink (input valid, pixel_offset, row_pattern, fore_color, back_color, last_row,
		output ready);
endinterface

/* src/text_console_glyph_renderer_top.sv */
// ----------------------------------------------------------------------------
// Text console glyph renderer
// Renders 8-pixel-wide bitmap glyphs at a text cursor as row writes.
//
//   channel   dir   beat contents
//   in_ch     in    opcode, character, glyph_row, glyph_bits
//   out_ch    out   pixel_offset, row_pattern, fore_color, back_color, last_row
//   cfg_*     in    write enable, register index, write data
//
// A print or erase runs from accept through five setup states, then issues
// one glyph store read per row while the output is not stalled, then returns
// to idle.
// A load ends after the decode state; newline and return end after the cursor move state.
// Each row beat passes through the read stage register and then the output register.
// Reset clears the cursor and restores the register defaults; the glyph
// store is not cleared. A stalled output holds its beat and stops row reads.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_top #(
	parameter int GLYPH_COUNT = tcgr_pkg::DEF_GLYPH_COUNT,
	parameter int GLYPH_HEIGHT = tcgr_pkg::DEF_GLYPH_HEIGHT,
	parameter int MAX_LINE_PIXELS = tcgr_pkg::DEF_MAX_LINE_PIXELS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tcgr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tcgr_pkg::CFG_W-1:0]     cfg_data,
	tcgr_in_if.sink                        in_ch,
	tcgr_out_if.source                     out_ch
);
	import tcgr_pkg::*;

	cmd_t    cmd;
	status_t status;

	tcgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	tcgr_datapath #(
		.GLYPH_COUNT     (GLYPH_COUNT),
		.GLYPH_HEIGHT    (GLYPH_HEIGHT),
		.MAX_LINE_PIXELS (MAX_LINE_PIXELS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_opcode        (in_ch.opcode),
		.in_character     (in_ch.character),
		.in_glyph_row     (in_ch.glyph_row),
		.in_glyph_bits    (in_ch.glyph_bits),
		.out_valid        (out_ch.valid),
		.out_ready        (out_ch.ready),
		.out_pixel_offset (out_ch.pixel_offset),
		.out_row_pattern  (out_ch.row_pattern),
		.out_fore_color   (out_ch.fore_color),
		.out_back_color   (out_ch.back_color),
		.out_last_row     (out_ch.last_row),
		.cmd              (cmd),
		.status           (status)
	);

endmodule

/* src/tcgr_ctrl.sv */
// ----------------------------------------------------------------------------
// Text console glyph renderer controller
// Sequences decode, geometry, cursor update, base address and row issue.
// ----------------------------------------------------------------------------
module tcgr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tcgr_pkg::status_t status,
	output tcgr_pkg::cmd_t    cmd
);
	import tcgr_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b000_0001,
		ST_DECODE = 7'b000_0010,
		ST_GEOM   = 7'b000_0100,
		ST_MOVE   = 7'b000_1000,
		ST_YROW   = 7'b001_0000,
		ST_BASE   = 7'b010_0000,
		ST_EMIT   = 7'b100_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
				if (status.kind == KIND_LOAD || status.kind == KIND_NONE) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_GEOM;
				end
			end
			ST_GEOM: begin
				cmd.geom = 1'b1;
				state_d = ST_MOVE;
			end
			ST_MOVE: begin
				cmd.move = 1'b1;
				if (status.kind == KIND_NEWLINE || status.kind == KIND_RETURN) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_YROW;
				end
			end
			ST_YROW: begin
				cmd.yrow = 1'b1;
				state_d = ST_BASE;
			end
			ST_BASE: begin
				cmd.base = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.issue = status.issue_ok;
				if (status.issue_ok && status.row_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* src/tcgr_datapath.sv */
// ----------------------------------------------------------------------------
// Text console glyph renderer datapath
// Configuration registers, cursor, glyph store, offset generation and the
// read and output register stages of the row writes.
// ----------------------------------------------------------------------------
module tcgr_datapath #(
	parameter int GLYPH_COUNT = tcgr_pkg::DEF_GLYPH_COUNT,
	parameter int GLYPH_HEIGHT = tcgr_pkg::DEF_GLYPH_HEIGHT,
	parameter int MAX_LINE_PIXELS = tcgr_pkg::DEF_MAX_LINE_PIXELS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tcgr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tcgr_pkg::CFG_W-1:0]    cfg_data,
	input  logic [tcgr_pkg::OP_W-1:0]     in_opcode,
	input  logic [tcgr_pkg::CHAR_W-1:0]   in_character,
	input  logic [tcgr_pkg::GROW_W-1:0]   in_glyph_row,
	input  logic [tcgr_pkg::BITS_W-1:0]   in_glyph_bits,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tcgr_pkg::OFFSET_W-1:0] out_pixel_offset,
	output logic [tcgr_pkg::BITS_W-1:0]   out_row_pattern,
	output logic [tcgr_pkg::COLOR_W-1:0]  out_fore_color,
	output logic [tcgr_pkg::COLOR_W-1:0]  out_back_color,
	output logic                          out_last_row,
	input  tcgr_pkg::cmd_t                cmd,
	output tcgr_pkg::status_t             status
);
	import tcgr_pkg::*;

	localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int STRIDE_W = $clog2(MAX_LINE_PIXELS + 1);
	localparam int CMP_W = (STRIDE_W > GEOM_W) ? STRIDE_W : GEOM_W;
	localparam int COLS_W = STRIDE_W - GLYPH_WIDTH_SH;
	localparam int COL_W = $clog2(MAX_LINE_PIXELS / GLYPH_WIDTH);
	localparam int CC_W = (COLS_W > COL_W + 1) ? COLS_W : COL_W + 1;
	localparam int X_W = COL_W + GLYPH_WIDTH_SH;
	localparam int ROW_W = $clog2(GLYPH_HEIGHT);
	localparam int GH_W = $clog2(GLYPH_HEIGHT + 1);
	localparam int GC_W = $clog2(GLYPH_COUNT + 1);
	localparam int Y0_W = $clog2((MAX_LINES - 1) * GLYPH_HEIGHT + 1);
	localparam int RECIP = (1 << RECIP_SHIFT) / GLYPH_HEIGHT;
	localparam int RECIP_W = $clog2(RECIP + 1);
	localparam int PROD_W = GEOM_W + RECIP_W;
	localparam int QEST_W = PROD_W - RECIP_SHIFT;
	localparam int QM_W = QEST_W + GH_W + 1;
	localparam int BP_W = ((Y0_W + STRIDE_W > X_W) ? Y0_W + STRIDE_W : X_W) + 1;

	logic [GEOM_W-1:0]  line_pixels_q;
	logic [GEOM_W-1:0]  screen_height_q;
	logic [COLOR_W-1:0] fg_color_q;
	logic [COLOR_W-1:0] bg_color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_pixels_q <= RST_LINE_PIXELS;
			screen_height_q <= RST_SCREEN_HEIGHT;
			fg_color_q <= RST_FG_COLOR;
			bg_color_q <= RST_BG_COLOR;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_LINE_PIXELS:   line_pixels_q <= cfg_data[GEOM_W-1:0];
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data[GEOM_W-1:0];
				REG_FG_COLOR:      fg_color_q <= cfg_data[COLOR_W-1:0];
				REG_BG_COLOR:      bg_color_q <= cfg_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	logic [OP_W-1:0]   op_q;
	logic [CHAR_W-1:0] char_q;
	logic [GROW_W-1:0] grow_q;
	logic [BITS_W-1:0] gbits_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= in_opcode;
			char_q <= in_character;
			grow_q <= in_glyph_row;
			gbits_q <= in_glyph_bits;
		end
	end

	kind_t kind;

	always_comb begin
		unique case (opcode_t'(op_q))
			OP_LOAD:  kind = KIND_LOAD;
			OP_ERASE: kind = KIND_ERASE;
			OP_PRINT: begin
				if (char_q == CHAR_NEWLINE) begin
					kind = KIND_NEWLINE;
				end else if (char_q == CHAR_RETURN) begin
					kind = KIND_RETURN;
				end else begin
					kind = KIND_PRINT;
				end
			end
			default: kind = KIND_NONE;
		endcase
	end

	// Scan line stride and the column count that follows from it.
	logic [CMP_W-1:0]    lp_ext;
	logic [STRIDE_W-1:0] stride;
	logic [COLS_W-1:0]   cols;

	assign lp_ext = CMP_W'(line_pixels_q);

	always_comb begin
		if (lp_ext < CMP_W'(GLYPH_WIDTH)) begin
			stride = STRIDE_W'(GLYPH_WIDTH);
		end else if (lp_ext > CMP_W'(MAX_LINE_PIXELS)) begin
			stride = STRIDE_W'(MAX_LINE_PIXELS);
		end else begin
			stride = lp_ext[STRIDE_W-1:0];
		end
	end

	assign cols = stride[STRIDE_W-1:GLYPH_WIDTH_SH];

	// Line count: reciprocal estimate, then a one-step correction and clamp.
	logic [PROD_W-1:0]  sh_prod;
	logic [QEST_W-1:0]  est_q;
	logic [QEST_W:0]    est_inc;
	logic [QM_W-1:0]    est_next_px;
	logic [QEST_W:0]    q_fix;
	logic [LINES_W-1:0] lines_q;

	assign sh_prod = PROD_W'(screen_height_q) * PROD_W'(RECIP);
	assign est_inc = {1'b0, est_q} + (QEST_W + 1)'(1);
	assign est_next_px = QM_W'(est_inc) * QM_W'(GLYPH_HEIGHT);
	assign q_fix = (QM_W'(screen_height_q) >= est_next_px) ? est_inc : {1'b0, est_q};

	always_ff @(posedge clk) begin
		if (cmd.decode) begin
			est_q <= sh_prod[PROD_W-1:RECIP_SHIFT];
		end
		if (cmd.geom) begin
			if (q_fix == '0) begin
				lines_q <= LINES_W'(1);
			end else if (q_fix > (QEST_W + 1)'(MAX_LINES)) begin
				lines_q <= LINES_W'(MAX_LINES);
			end else begin
				lines_q <= LINES_W'(q_fix);
			end
		end
	end

	// Cursor.
	logic [COL_W-1:0]   col_q;
	logic [LINE_W-1:0]  line_q;
	logic [LINES_W-1:0] line_inc;
	logic               line_wrap;
	logic [CC_W-1:0]    col_inc;
	logic               col_wrap;
	logic [LINE_W-1:0]  line_down;

	assign line_inc = {1'b0, line_q} + LINES_W'(1);
	assign line_wrap = (line_inc >= lines_q);
	assign line_down = line_wrap ? '0 : line_inc[LINE_W-1:0];
	assign col_inc = CC_W'(col_q) + CC_W'(1);
	assign col_wrap = (col_inc >= CC_W'(cols));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			line_q <= '0;
		end else if (cmd.move) begin
			if (kind == KIND_NEWLINE) begin
				line_q <= line_down;
			end else if (kind == KIND_RETURN) begin
				col_q <= '0;
			end else if (kind == KIND_ERASE) begin
				if (col_q == '0) begin
					col_q <= COL_W'(cols - COLS_W'(1));
					if (line_q == '0) begin
						line_q <= LINE_W'(lines_q - LINES_W'(1));
					end else begin
						line_q <= line_q - LINE_W'(1);
					end
				end else begin
					col_q <= col_q - COL_W'(1);
				end
			end
		end else if (cmd.base && kind == KIND_PRINT) begin
			if (col_wrap) begin
				col_q <= '0;
				line_q <= line_down;
			end else begin
				col_q <= col_inc[COL_W-1:0];
			end
		end
	end

	// Cell origin and per-row offset.
	logic [Y0_W-1:0]     y0_q;
	logic [X_W-1:0]      x_px;
	logic [BP_W-1:0]     base_sum;
	logic [OFFSET_W-1:0] off_q;
	logic [ADDR_W-1:0]   gbase_q;
	logic                zero_q;
	logic                erase_q;
	logic [ROW_W-1:0]    row_q;
	logic                char_ok;
	logic                row_ok;

	assign x_px = {col_q, {GLYPH_WIDTH_SH{1'b0}}};
	assign base_sum = BP_W'(x_px) + BP_W'(y0_q) * BP_W'(stride);
	assign char_ok = (GC_W'(char_q) < GC_W'(GLYPH_COUNT));
	assign row_ok = (GH_W'(grow_q) < GH_W'(GLYPH_HEIGHT));

	always_ff @(posedge clk) begin
		if (cmd.yrow) begin
			y0_q <= Y0_W'(line_q) * Y0_W'(GLYPH_HEIGHT);
		end
		if (cmd.base) begin
			off_q <= OFFSET_W'(base_sum);
			gbase_q <= ADDR_W'(int'(char_q) * GLYPH_HEIGHT);
			zero_q <= (kind == KIND_ERASE) || !char_ok;
			erase_q <= (kind == KIND_ERASE);
		end else if (cmd.issue) begin
			off_q <= off_q + OFFSET_W'(stride);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (cmd.base) begin
			row_q <= '0;
		end else if (cmd.issue) begin
			row_q <= row_q + ROW_W'(1);
		end
	end

	// Glyph store: written by loads, read one row per issued beat.
	logic [BITS_W-1:0] glyph_mem [STORE_DEPTH];
	logic [BITS_W-1:0] rdata_s1;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;

	assign wr_addr = ADDR_W'(int'(char_q) * GLYPH_HEIGHT + int'(grow_q));
	assign rd_addr = gbase_q + ADDR_W'(row_q);
	assign wr_en = cmd.decode && (kind == KIND_LOAD) && char_ok && row_ok;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			glyph_mem[wr_addr] <= gbits_q;
		end
		if (cmd.issue) begin
			rdata_s1 <= glyph_mem[rd_addr];
		end
	end

	// Read stage and output register.
	logic                vld_s1;
	logic [OFFSET_W-1:0] off_s1;
	logic                last_s1;
	logic                zero_s1;
	logic                erase_s1;
	logic                move_s1;
	logic                row_last;
	logic                out_vld_q;
	logic [OFFSET_W-1:0] out_off_q;
	logic [BITS_W-1:0]   out_pat_q;
	logic [COLOR_W-1:0]  out_fore_q;
	logic [COLOR_W-1:0]  out_back_q;
	logic                out_last_q;

	assign row_last = (row_q == ROW_W'(GLYPH_HEIGHT - 1));
	assign move_s1 = vld_s1 && (!out_vld_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.issue) begin
				vld_s1 <= 1'b1;
			end else if (move_s1) begin
				vld_s1 <= 1'b0;
			end
			if (move_s1) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			off_s1 <= off_q;
			last_s1 <= row_last;
			zero_s1 <= zero_q;
			erase_s1 <= erase_q;
		end
		if (move_s1) begin
			out_off_q <= off_s1;
			out_pat_q <= zero_s1 ? '0 : rdata_s1;
			out_fore_q <= erase_s1 ? bg_color_q : fg_color_q;
			out_back_q <= bg_color_q;
			out_last_q <= last_s1;
		end
	end

	assign out_valid = out_vld_q;
	assign out_pixel_offset = out_off_q;
	assign out_row_pattern = out_pat_q;
	assign out_fore_color = out_fore_q;
	assign out_back_color = out_back_q;
	assign out_last_row = out_last_q;

	assign status.kind = kind;
	assign status.issue_ok = !vld_s1 || move_s1;
	assign status.row_last = row_last;

endmodule

/* src/tcgr_checker.sv */
// ----------------------------------------------------------------------------
// Text console glyph renderer port checker
// Watches the output channel for beats held while stalled, against the
// configured colors and against the cell row count.
// ----------------------------------------------------------------------------
module tcgr_checker #(
	parameter int GLYPH_HEIGHT = tcgr_pkg::DEF_GLYPH_HEIGHT
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_we,
	input logic [tcgr_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [tcgr_pkg::CFG_W-1:0]     cfg_data,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [tcgr_pkg::OFFSET_W-1:0]  out_pixel_offset,
	input logic [tcgr_pkg::BITS_W-1:0]    out_row_pattern,
	input logic [tcgr_pkg::COLOR_W-1:0]   out_fore_color,
	input logic [tcgr_pkg::COLOR_W-1:0]   out_back_color,
	input logic                           out_last_row
);
	import tcgr_pkg::*;

	localparam int CNT_W = $clog2(GLYPH_HEIGHT);

	logic [COLOR_W-1:0] fg_q;
	logic [COLOR_W-1:0] bg_q;
	logic [CNT_W-1:0]   beat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= RST_FG_COLOR;
			bg_q <= RST_BG_COLOR;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_FG_COLOR: fg_q <= cfg_data[COLOR_W-1:0];
				REG_BG_COLOR: bg_q <= cfg_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q <= '0;
		end else if (out_valid && out_ready) begin
			beat_q <= out_last_row ? '0 : beat_q + CNT_W'(1);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_pixel_offset)
			&& $stable(out_row_pattern) && $stable(out_last_row))
		else $error("Output beat changed while stalled.");

	a_back_color: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_back_color == bg_q)
		else $error("Background color differs from the configured value.");

	a_fore_color: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_fore_color == fg_q || out_fore_color == bg_q)
		else $error("Foreground color is neither configured color.");

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> out_last_row == (beat_q == CNT_W'(GLYPH_HEIGHT - 1)))
		else $error("Last row mark does not fall on the final row of a cell.");

endmodule

bind text_console_glyph_renderer_top tcgr_checker #(
	.GLYPH_HEIGHT (GLYPH_HEIGHT)
) u_tcgr_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cfg_we           (cfg_we),
	.cfg_index        (cfg_index),
	.cfg_data         (cfg_data),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.out_pixel_offset (out_ch.pixel_offset),
	.out_row_pattern  (out_ch.row_pattern),
	.out_fore_color   (out_ch.fore_color),
	.out_back_color   (out_ch.back_color),
	.out_last_row     (out_ch.last_row)
);
